FILE: rtl/string_literal_scanner_assert.svh
// Assertion macros used by the scanner core.
// Both sample on the rising edge of clk and are switched off while rst is high.
`ifndef STRING_LITERAL_SCANNER_ASSERT_SVH
`define STRING_LITERAL_SCANNER_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define SLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sls_pkg.sv
package sls_pkg;

  // Scanner modes.
  typedef enum logic [3:0] {
    M_IDLE,
    M_Q_BODY,
    M_Q_ESC,
    M_Q_HEX,
    M_Q_UOPEN,
    M_Q_UNI,
    M_R_HASH,
    M_R_BODY,
    M_R_CLOSE,
    M_T_OPEN,
    M_T_BODY,
    M_T_ESC
  } scan_mode_t;

  // Token kinds reported with each result.
  typedef enum logic [2:0] {
    K_QUOTED  = 3'd0,
    K_RAW     = 3'd1,
    K_TEX     = 3'd2,
    K_UNKNOWN = 3'd3,
    K_NOT_LIT = 3'd4
  } token_kind_t;

  localparam int TOKEN_LENGTH_W = 16;

  // Escape mark bits.
  localparam logic [2:0] ESC_NAMED = 3'b001;
  localparam logic [2:0] ESC_HEX   = 3'b010;
  localparam logic [2:0] ESC_UNI   = 3'b100;

  // Characters the scanner looks for.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } item_t;

  // One result beat.
  typedef struct packed {
    token_kind_t                 kind;
    logic [TOKEN_LENGTH_W-1:0]   length;
    logic                        named;
    logic                        hex;
    logic                        uni;
    logic                        unterminated;
    logic                        taken;
  } result_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_named_escape(input logic [7:0] c);
    return c inside {CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_BACKSLASH, CH_QUOTE,
                     CH_APOS, CH_ZERO};
  endfunction

endpackage

FILE: rtl/sls_in_stage.sv
module sls_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  sls_pkg::item_t      item_in,
  output logic                item_valid,
  output sls_pkg::item_t      item,
  input  logic                item_fire
);

  logic accept;

  // The register frees up in the same cycle that the core consumes its beat.
  assign byte_ready = !item_valid || item_fire;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_fire) begin
      item_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

endmodule

FILE: rtl/sls_scan_core.sv
`include "string_literal_scanner_assert.svh"

module sls_scan_core #(
  parameter int MAX_HASHES  = 255,
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_fire,
  input  sls_pkg::item_t      item,
  output logic                result_valid,
  output sls_pkg::result_t    result
);

  localparam int HashW = $clog2(MAX_HASHES + 1);

  sls_pkg::scan_mode_t     mode, mode_next, eff;
  logic [HashW-1:0]        open_hashes, open_hashes_next;
  logic [HashW-1:0]        close_hashes, close_hashes_next, close_inc;
  logic [1:0]              hex_left, hex_left_next, hex_dec;
  logic [LENGTH_BITS-1:0]  count, count_next, count_inc;
  logic [2:0]              esc, esc_next;
  logic                    fall, take, emit;
  logic [7:0]              c;

  assign c         = item.in_byte;
  assign close_inc = close_hashes + 1'b1;
  assign hex_dec   = hex_left - 2'd1;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sls_pkg::M_IDLE;
      open_hashes  <= '0;
      close_hashes <= '0;
      hex_left     <= '0;
      count        <= '0;
      esc          <= '0;
    end else if (item_fire) begin
      mode         <= mode_next;
      open_hashes  <= open_hashes_next;
      close_hashes <= close_hashes_next;
      hex_left     <= hex_left_next;
      count        <= count_next;
      esc          <= esc_next;
    end
  end

  // One scan step: a byte that ends an escape or a closing run unclaimed falls
  // back to the body mode and is examined there in the same step.
  always_comb begin
    fall = 1'b0;
    eff  = mode;
    case (mode)
      sls_pkg::M_Q_HEX: begin
        fall = !sls_pkg::is_hex(c);
      end
      sls_pkg::M_Q_UOPEN: begin
        fall = (c != sls_pkg::CH_LBRACE);
      end
      sls_pkg::M_Q_UNI: begin
        fall = (c != sls_pkg::CH_RBRACE) && !sls_pkg::is_hex(c);
      end
      sls_pkg::M_R_CLOSE: begin
        fall = (c != sls_pkg::CH_HASH);
      end
      sls_pkg::M_T_ESC: begin
        fall = (c != sls_pkg::CH_QUOTE);
      end
      default: begin
        fall = 1'b0;
      end
    endcase
    if (fall) begin
      case (mode)
        sls_pkg::M_R_CLOSE: eff = sls_pkg::M_R_BODY;
        sls_pkg::M_T_ESC:   eff = sls_pkg::M_T_BODY;
        default:            eff = sls_pkg::M_Q_BODY;
      endcase
    end

    mode_next         = eff;
    open_hashes_next  = open_hashes;
    close_hashes_next = (fall && mode == sls_pkg::M_R_CLOSE) ? '0 : close_hashes;
    hex_left_next     = (fall && mode == sls_pkg::M_Q_HEX) ? 2'd0 : hex_left;
    esc_next          = esc;
    take              = 1'b0;
    emit              = 1'b0;
    result.kind         = sls_pkg::K_UNKNOWN;
    result.named        = 1'b0;
    result.hex          = 1'b0;
    result.uni          = 1'b0;
    result.unterminated = 1'b0;
    result.taken        = 1'b0;

    if (item.end_of_input) begin
      // End of input always closes the current token.
      emit = 1'b1;
      case (mode)
        sls_pkg::M_Q_BODY, sls_pkg::M_Q_ESC, sls_pkg::M_Q_HEX,
        sls_pkg::M_Q_UOPEN, sls_pkg::M_Q_UNI: begin
          result.kind         = sls_pkg::K_QUOTED;
          result.named        = esc[0];
          result.hex          = esc[1];
          result.uni          = esc[2];
          result.unterminated = 1'b1;
        end
        sls_pkg::M_R_BODY, sls_pkg::M_R_CLOSE: begin
          result.kind = sls_pkg::K_RAW;
        end
        sls_pkg::M_T_BODY, sls_pkg::M_T_ESC: begin
          result.kind  = sls_pkg::K_TEX;
          result.named = esc[0];
          result.hex   = esc[1];
          result.uni   = esc[2];
        end
        default: begin
          result.kind = sls_pkg::K_UNKNOWN;
        end
      endcase
    end else begin
      case (eff)
        // Quoted string body and its escapes.
        sls_pkg::M_Q_BODY: begin
          take = 1'b1;
          if (c == sls_pkg::CH_QUOTE) begin
            emit         = 1'b1;
            result.kind  = sls_pkg::K_QUOTED;
            result.named = esc[0];
            result.hex   = esc[1];
            result.uni   = esc[2];
            result.taken = 1'b1;
          end else if (c == sls_pkg::CH_BACKSLASH) begin
            mode_next = sls_pkg::M_Q_ESC;
          end
        end
        sls_pkg::M_Q_ESC: begin
          take = 1'b1;
          if (sls_pkg::is_named_escape(c)) begin
            esc_next  = esc | sls_pkg::ESC_NAMED;
            mode_next = sls_pkg::M_Q_BODY;
          end else if (c == sls_pkg::CH_LOWER_X) begin
            esc_next      = esc | sls_pkg::ESC_HEX;
            hex_left_next = 2'd2;
            mode_next     = sls_pkg::M_Q_HEX;
          end else if (c == sls_pkg::CH_LOWER_U) begin
            esc_next  = esc | sls_pkg::ESC_UNI;
            mode_next = sls_pkg::M_Q_UOPEN;
          end else begin
            mode_next = sls_pkg::M_Q_BODY;
          end
        end
        sls_pkg::M_Q_HEX: begin
          take          = 1'b1;
          hex_left_next = hex_dec;
          if (hex_dec == 2'd0) begin
            mode_next = sls_pkg::M_Q_BODY;
          end
        end
        sls_pkg::M_Q_UOPEN: begin
          take      = 1'b1;
          mode_next = sls_pkg::M_Q_UNI;
        end
        sls_pkg::M_Q_UNI: begin
          take = 1'b1;
          if (c == sls_pkg::CH_RBRACE) begin
            mode_next = sls_pkg::M_Q_BODY;
          end
        end
        // Raw string: opening hashes, body, closing run.
        sls_pkg::M_R_HASH: begin
          if (c == sls_pkg::CH_HASH) begin
            take = 1'b1;
            if (open_hashes < HashW'(MAX_HASHES)) begin
              open_hashes_next = open_hashes + 1'b1;
            end
          end else if (c == sls_pkg::CH_QUOTE) begin
            take      = 1'b1;
            mode_next = sls_pkg::M_R_BODY;
          end else begin
            emit = 1'b1;
          end
        end
        sls_pkg::M_R_BODY: begin
          take = 1'b1;
          if (c == sls_pkg::CH_QUOTE) begin
            if (open_hashes == '0) begin
              emit         = 1'b1;
              result.kind  = sls_pkg::K_RAW;
              result.taken = 1'b1;
            end else begin
              close_hashes_next = '0;
              mode_next         = sls_pkg::M_R_CLOSE;
            end
          end
        end
        sls_pkg::M_R_CLOSE: begin
          take              = 1'b1;
          close_hashes_next = close_inc;
          if (close_inc >= open_hashes) begin
            emit         = 1'b1;
            result.kind  = sls_pkg::K_RAW;
            result.taken = 1'b1;
          end
        end
        // TeX string.
        sls_pkg::M_T_OPEN: begin
          if (c == sls_pkg::CH_QUOTE) begin
            take      = 1'b1;
            mode_next = sls_pkg::M_T_BODY;
          end else begin
            emit = 1'b1;
          end
        end
        sls_pkg::M_T_BODY: begin
          take = 1'b1;
          if (c == sls_pkg::CH_QUOTE) begin
            emit         = 1'b1;
            result.kind  = sls_pkg::K_TEX;
            result.named = esc[0];
            result.hex   = esc[1];
            result.uni   = esc[2];
            result.taken = 1'b1;
          end else if (c == sls_pkg::CH_BACKSLASH) begin
            mode_next = sls_pkg::M_T_ESC;
          end
        end
        sls_pkg::M_T_ESC: begin
          take      = 1'b1;
          esc_next  = esc | sls_pkg::ESC_NAMED;
          mode_next = sls_pkg::M_T_BODY;
        end
        // Idle: the first byte picks the literal kind.
        default: begin
          if (c == sls_pkg::CH_QUOTE) begin
            take      = 1'b1;
            mode_next = sls_pkg::M_Q_BODY;
          end else if (c == sls_pkg::CH_LOWER_R) begin
            take      = 1'b1;
            mode_next = sls_pkg::M_R_HASH;
          end else if (c == sls_pkg::CH_LOWER_T) begin
            take      = 1'b1;
            mode_next = sls_pkg::M_T_OPEN;
          end else begin
            emit        = 1'b1;
            result.kind = sls_pkg::K_NOT_LIT;
          end
        end
      endcase
    end

    // The length counter holds at its maximum.
    count_inc     = (take && count != '1) ? count + 1'b1 : count;
    count_next    = count_inc;
    result.length = 16'(count_inc);
    // A finished token leaves the scanner idle and cleared.
    if (emit) begin
      mode_next         = sls_pkg::M_IDLE;
      open_hashes_next  = '0;
      close_hashes_next = '0;
      hex_left_next     = '0;
      count_next        = '0;
      esc_next          = '0;
    end
  end

  assign result_valid  = item_fire && emit;

  `SLS_ASSERT_NEXT(a_idle_after_emit, result_valid, mode == sls_pkg::M_IDLE && count == '0, "scanner not cleared after a result")
  `SLS_ASSERT_SAME(a_hex_only_in_hex, hex_left != 2'd0, mode == sls_pkg::M_Q_HEX, "hex digit budget left outside hex escape")
  `SLS_ASSERT_SAME(a_close_run, close_hashes != '0, mode == sls_pkg::M_R_CLOSE && close_hashes < open_hashes, "closing hash run out of range")
  `SLS_ASSERT_SAME(a_unterm_kind, result_valid && result.unterminated, result.kind == sls_pkg::K_QUOTED && !result.taken, "unterminated mark on a wrong result")
  `SLS_ASSERT_SAME(a_idle_clear, mode == sls_pkg::M_IDLE, esc == '0 && count == '0 && open_hashes == '0, "idle scanner holds token state")

endmodule

FILE: rtl/sls_out_stage.sv
module sls_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                result_valid,
  input  sls_pkg::result_t    result_in,
  output logic                result_ready,
  output logic                token_valid,
  input  logic                token_ready,
  output sls_pkg::result_t    result
);

  // The register can take a new beat when empty or being drained this cycle.
  assign result_ready = !token_valid || token_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (result_ready) begin
      token_valid <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready && result_valid) begin
      result <= result_in;
    end
  end

endmodule

FILE: rtl/string_literal_scanner.sv
// String literal scanner. Feed one source byte per beat, starting at the first byte of a
// literal, or an end-of-input beat. Quoted, raw (hash-delimited) and TeX strings are
// recognized; a beat yields at most one result, emitted when the token completes, when
// end of input is seen, or when the byte does not start or continue a literal (then
// byte_taken is 0 and the caller presents that byte again). Each beat passes through a
// single scan step between an input register and a result register, so the block
// sustains one byte per cycle while token_ready is high; the result of a byte is written
// to the result register as the byte leaves the input register. While a result waits
// with token_ready low, the input stalls. MAX_HASHES bounds the counted opening hashes
// and LENGTH_BITS the saturating length counter, of which the low 16 bits are reported.
module string_literal_scanner #(
  parameter int MAX_HASHES  = 255,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [15:0] token_length,
  output logic        has_named_escape,
  output logic        has_hex_escape,
  output logic        has_unicode_escape,
  output logic        unterminated,
  output logic        byte_taken
);

  sls_pkg::item_t   item_in, item;
  sls_pkg::result_t step_result, result;
  logic             item_valid, item_fire, step_valid, result_ready;

  assign item_in.in_byte      = in_byte;
  assign item_in.end_of_input = end_of_input;

  // A beat moves through the scan step whenever the result register can take it.
  assign item_fire = item_valid && result_ready;

  sls_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item),
    .item_fire  (item_fire)
  );

  sls_scan_core #(
    .MAX_HASHES  (MAX_HASHES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .item_fire    (item_fire),
    .item         (item),
    .result_valid (step_valid),
    .result       (step_result)
  );

  sls_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .result_valid (step_valid),
    .result_in    (step_result),
    .result_ready (result_ready),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .result       (result)
  );

  assign token_kind         = result.kind;
  assign token_length       = result.length;
  assign has_named_escape   = result.named;
  assign has_hex_escape     = result.hex;
  assign has_unicode_escape = result.uni;
  assign unterminated       = result.unterminated;
  assign byte_taken         = result.taken;

endmodule

FILE: test/tb_string_literal_scanner.sv
module tb_string_literal_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_BEATS = 260;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] FILL_BYTE = 8'h61;

  // One row of the directed table; typed rows carry the result written out by hand.
  typedef struct packed {
    logic [7:0]       b;
    logic             eoi;
    logic             typed;
    sls_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        token_valid;
  logic        token_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [15:0] token_length;
  logic        has_named_escape;
  logic        has_hex_escape;
  logic        has_unicode_escape;
  logic        unterminated;
  logic        byte_taken;

  sls_pkg::result_t pending_tokens[$];
  stim_row_t        directed_rows[$];
  int               mismatch_count = 0;
  int               tokens_checked = 0;
  int               beats_sent = 0;
  int               quiet_cycles = 0;
  bit               tx_quiet = 1'b0;
  bit               rx_quiet = 1'b0;
  bit               rx_holding = 1'b0;

  // Scanner state as the testbench tracks it.
  sls_pkg::scan_mode_t                sc_mode;
  int unsigned                        open_hashes;
  int unsigned                        close_hashes;
  logic [1:0]                         hex_left;
  logic [sls_pkg::TOKEN_LENGTH_W-1:0] tok_len;
  logic [2:0]                         esc_seen;

  string_literal_scanner DUT (
    .clk                (clk),
    .rst                (rst),
    .byte_valid         (byte_valid),
    .byte_ready         (byte_ready),
    .in_byte            (in_byte),
    .end_of_input       (end_of_input),
    .token_valid        (token_valid),
    .token_ready        (token_ready),
    .token_kind         (token_kind),
    .token_length       (token_length),
    .has_named_escape   (has_named_escape),
    .has_hex_escape     (has_hex_escape),
    .has_unicode_escape (has_unicode_escape),
    .unterminated       (unterminated),
    .byte_taken         (byte_taken)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_scan();
    sc_mode = sls_pkg::M_IDLE;
    open_hashes = 0;
    close_hashes = 0;
    hex_left = '0;
    tok_len = '0;
    esc_seen = '0;
  endfunction

  function automatic void count_byte();
    if (tok_len != '1) begin
      tok_len = tok_len + 1'b1;
    end
  endfunction

  function automatic bit hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic bit named_escape(input logic [7:0] c);
    return c == sls_pkg::CH_LOWER_N || c == sls_pkg::CH_LOWER_R ||
           c == sls_pkg::CH_LOWER_T || c == sls_pkg::CH_BACKSLASH ||
           c == sls_pkg::CH_QUOTE || c == sls_pkg::CH_APOS || c == sls_pkg::CH_ZERO;
  endfunction

  // Builds the result of the token in progress and returns the scanner to idle.
  function automatic bit close_token(input sls_pkg::token_kind_t kind,
                                     input logic [2:0] flags,
                                     input logic unterm, input logic taken,
                                     output sls_pkg::result_t r);
    r.kind = kind;
    r.length = tok_len;
    r.named = |(flags & sls_pkg::ESC_NAMED);
    r.hex = |(flags & sls_pkg::ESC_HEX);
    r.uni = |(flags & sls_pkg::ESC_UNI);
    r.unterminated = unterm;
    r.taken = taken;
    clear_scan();
    return 1'b1;
  endfunction

  // Advances the tracked scanner by one beat; returns 1 when that beat ends a token.
  function automatic bit scan_step(input logic [7:0] c, input logic eoi,
                                   output sls_pkg::result_t r);
    bit got;
    bit again;
    got = 1'b0;
    r = '0;
    if (eoi) begin
      case (sc_mode)
        sls_pkg::M_IDLE: got = close_token(sls_pkg::K_UNKNOWN, 3'b000, 1'b0, 1'b0, r);
        sls_pkg::M_Q_BODY, sls_pkg::M_Q_ESC, sls_pkg::M_Q_HEX, sls_pkg::M_Q_UOPEN,
        sls_pkg::M_Q_UNI:
          got = close_token(sls_pkg::K_QUOTED, esc_seen, 1'b1, 1'b0, r);
        sls_pkg::M_R_BODY, sls_pkg::M_R_CLOSE:
          got = close_token(sls_pkg::K_RAW, 3'b000, 1'b0, 1'b0, r);
        sls_pkg::M_T_BODY, sls_pkg::M_T_ESC:
          got = close_token(sls_pkg::K_TEX, esc_seen, 1'b0, 1'b0, r);
        default: got = close_token(sls_pkg::K_UNKNOWN, 3'b000, 1'b0, 1'b0, r);
      endcase
      return got;
    end
    // A byte handed back by a sub-state is looked at again as body content.
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (sc_mode)
        sls_pkg::M_Q_BODY: begin
          count_byte();
          if (c == sls_pkg::CH_QUOTE)
            got = close_token(sls_pkg::K_QUOTED, esc_seen, 1'b0, 1'b1, r);
          else if (c == sls_pkg::CH_BACKSLASH) sc_mode = sls_pkg::M_Q_ESC;
        end
        sls_pkg::M_Q_ESC: begin
          count_byte();
          if (named_escape(c)) begin
            esc_seen = esc_seen | sls_pkg::ESC_NAMED;
            sc_mode = sls_pkg::M_Q_BODY;
          end else if (c == sls_pkg::CH_LOWER_X) begin
            esc_seen = esc_seen | sls_pkg::ESC_HEX;
            hex_left = 2'd2;
            sc_mode = sls_pkg::M_Q_HEX;
          end else if (c == sls_pkg::CH_LOWER_U) begin
            esc_seen = esc_seen | sls_pkg::ESC_UNI;
            sc_mode = sls_pkg::M_Q_UOPEN;
          end else begin
            sc_mode = sls_pkg::M_Q_BODY;
          end
        end
        sls_pkg::M_Q_HEX: begin
          if (hex_digit(c)) begin
            count_byte();
            hex_left = hex_left - 2'd1;
            if (hex_left == 2'd0) sc_mode = sls_pkg::M_Q_BODY;
          end else begin
            hex_left = '0;
            sc_mode = sls_pkg::M_Q_BODY;
            again = 1'b1;
          end
        end
        sls_pkg::M_Q_UOPEN: begin
          if (c == sls_pkg::CH_LBRACE) begin
            count_byte();
            sc_mode = sls_pkg::M_Q_UNI;
          end else begin
            sc_mode = sls_pkg::M_Q_BODY;
            again = 1'b1;
          end
        end
        sls_pkg::M_Q_UNI: begin
          if (c == sls_pkg::CH_RBRACE) begin
            count_byte();
            sc_mode = sls_pkg::M_Q_BODY;
          end else if (hex_digit(c)) begin
            count_byte();
          end else begin
            sc_mode = sls_pkg::M_Q_BODY;
            again = 1'b1;
          end
        end
        sls_pkg::M_R_HASH: begin
          if (c == sls_pkg::CH_HASH) begin
            count_byte();
            if (open_hashes < 255) open_hashes++;
          end else if (c == sls_pkg::CH_QUOTE) begin
            count_byte();
            sc_mode = sls_pkg::M_R_BODY;
          end else begin
            got = close_token(sls_pkg::K_UNKNOWN, 3'b000, 1'b0, 1'b0, r);
          end
        end
        sls_pkg::M_R_BODY: begin
          count_byte();
          if (c == sls_pkg::CH_QUOTE) begin
            if (open_hashes == 0) begin
              got = close_token(sls_pkg::K_RAW, 3'b000, 1'b0, 1'b1, r);
            end else begin
              close_hashes = 0;
              sc_mode = sls_pkg::M_R_CLOSE;
            end
          end
        end
        sls_pkg::M_R_CLOSE: begin
          if (c == sls_pkg::CH_HASH) begin
            count_byte();
            close_hashes++;
            if (close_hashes >= open_hashes)
              got = close_token(sls_pkg::K_RAW, 3'b000, 1'b0, 1'b1, r);
          end else begin
            close_hashes = 0;
            sc_mode = sls_pkg::M_R_BODY;
            again = 1'b1;
          end
        end
        sls_pkg::M_T_OPEN: begin
          if (c == sls_pkg::CH_QUOTE) begin
            count_byte();
            sc_mode = sls_pkg::M_T_BODY;
          end else begin
            got = close_token(sls_pkg::K_UNKNOWN, 3'b000, 1'b0, 1'b0, r);
          end
        end
        sls_pkg::M_T_BODY: begin
          count_byte();
          if (c == sls_pkg::CH_QUOTE)
            got = close_token(sls_pkg::K_TEX, esc_seen, 1'b0, 1'b1, r);
          else if (c == sls_pkg::CH_BACKSLASH) sc_mode = sls_pkg::M_T_ESC;
        end
        sls_pkg::M_T_ESC: begin
          if (c == sls_pkg::CH_QUOTE) begin
            count_byte();
            esc_seen = esc_seen | sls_pkg::ESC_NAMED;
            sc_mode = sls_pkg::M_T_BODY;
          end else begin
            sc_mode = sls_pkg::M_T_BODY;
            again = 1'b1;
          end
        end
        default: begin
          clear_scan();
          if (c == sls_pkg::CH_QUOTE) begin
            count_byte();
            sc_mode = sls_pkg::M_Q_BODY;
          end else if (c == sls_pkg::CH_LOWER_R) begin
            count_byte();
            sc_mode = sls_pkg::M_R_HASH;
          end else if (c == sls_pkg::CH_LOWER_T) begin
            count_byte();
            sc_mode = sls_pkg::M_T_OPEN;
          end else begin
            got = close_token(sls_pkg::K_NOT_LIT, 3'b000, 1'b0, 1'b0, r);
          end
        end
      endcase
    end
    return got;
  endfunction

  // Offers one input beat after a random gap and records what it should produce.
  task automatic send_row(input stim_row_t row);
    int gap;
    bit produced;
    sls_pkg::result_t predicted;
    gap = (tx_quiet || rx_holding) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    in_byte <= row.b;
    end_of_input <= row.eoi;
    do @(posedge clk); while (!byte_ready);
    produced = scan_step(row.b, row.eoi, predicted);
    if (row.typed) pending_tokens.push_back(row.want);
    else if (produced) pending_tokens.push_back(predicted);
    beats_sent++;
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eoi);
    stim_row_t row;
    row = '0;
    row.b = b;
    row.eoi = eoi;
    send_row(row);
  endtask

  function automatic void add_row(input logic [7:0] b, input logic eoi);
    stim_row_t row;
    row = '0;
    row.b = b;
    row.eoi = eoi;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [7:0] b, input logic eoi,
                                      input sls_pkg::token_kind_t kind, input int len,
                                      input logic n, input logic h, input logic u,
                                      input logic unterm, input logic taken);
    stim_row_t row;
    row.b = b;
    row.eoi = eoi;
    row.typed = 1'b1;
    row.want.kind = kind;
    row.want.length = len[sls_pkg::TOKEN_LENGTH_W-1:0];
    row.want.named = n;
    row.want.hex = h;
    row.want.uni = u;
    row.want.unterminated = unterm;
    row.want.taken = taken;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Body content: mostly bytes that neither close nor escape.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = any_byte();
    if ($urandom_range(0, 19) != 0 && (b == sls_pkg::CH_QUOTE || b == sls_pkg::CH_BACKSLASH))
      b = FILL_BYTE;
    return b;
  endfunction

  function automatic logic [7:0] hex_pick();
    case ($urandom_range(0, 4))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h61 + 8'($urandom_range(0, 5));
      2: return 8'h41 + 8'($urandom_range(0, 5));
      3: return 8'h30 + 8'($urandom_range(0, 9));
      default: return any_byte();
    endcase
  endfunction

  function automatic logic [7:0] named_pick();
    case ($urandom_range(0, 6))
      0: return sls_pkg::CH_LOWER_N;
      1: return sls_pkg::CH_LOWER_R;
      2: return sls_pkg::CH_LOWER_T;
      3: return sls_pkg::CH_BACKSLASH;
      4: return sls_pkg::CH_QUOTE;
      5: return sls_pkg::CH_APOS;
      default: return sls_pkg::CH_ZERO;
    endcase
  endfunction

  task automatic send_end();
    send_beat(any_byte(), 1'b1);
  endtask

  task automatic send_quoted();
    int n;
    send_beat(sls_pkg::CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          send_beat(sls_pkg::CH_BACKSLASH, 1'b0);
          send_beat(named_pick(), 1'b0);
        end
        1: begin
          send_beat(sls_pkg::CH_BACKSLASH, 1'b0);
          send_beat(sls_pkg::CH_LOWER_X, 1'b0);
          repeat ($urandom_range(0, 3)) send_beat(hex_pick(), 1'b0);
        end
        2: begin
          send_beat(sls_pkg::CH_BACKSLASH, 1'b0);
          send_beat(sls_pkg::CH_LOWER_U, 1'b0);
          if ($urandom_range(0, 3) != 0) begin
            send_beat(sls_pkg::CH_LBRACE, 1'b0);
            repeat ($urandom_range(0, 6)) send_beat(hex_pick(), 1'b0);
            if ($urandom_range(0, 3) != 0) send_beat(sls_pkg::CH_RBRACE, 1'b0);
          end
        end
        3: begin
          send_beat(sls_pkg::CH_BACKSLASH, 1'b0);
          send_beat(any_byte(), 1'b0);
        end
        default: send_beat(body_byte(), 1'b0);
      endcase
    end
    if ($urandom_range(0, 9) == 0) send_end();
    else send_beat(sls_pkg::CH_QUOTE, 1'b0);
  endtask

  task automatic send_raw();
    int hashes;
    int n;
    hashes = $urandom_range(0, 4);
    send_beat(sls_pkg::CH_LOWER_R, 1'b0);
    repeat (hashes) send_beat(sls_pkg::CH_HASH, 1'b0);
    // Sometimes the opening quote is missing.
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) send_beat(any_byte(), 1'b0);
      else send_end();
      return;
    end
    send_beat(sls_pkg::CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    repeat (n) begin
      if (hashes > 0 && $urandom_range(0, 3) == 0) begin
        send_beat(sls_pkg::CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, hashes - 1)) send_beat(sls_pkg::CH_HASH, 1'b0);
      end else begin
        send_beat(body_byte(), 1'b0);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_end();
    end else begin
      send_beat(sls_pkg::CH_QUOTE, 1'b0);
      repeat (hashes) send_beat(sls_pkg::CH_HASH, 1'b0);
    end
  endtask

  task automatic send_tex();
    int n;
    send_beat(sls_pkg::CH_LOWER_T, 1'b0);
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) send_beat(any_byte(), 1'b0);
      else send_end();
      return;
    end
    send_beat(sls_pkg::CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(sls_pkg::CH_BACKSLASH, 1'b0);
        send_beat(($urandom_range(0, 1) == 0) ? sls_pkg::CH_QUOTE : any_byte(), 1'b0);
      end else begin
        send_beat(body_byte(), 1'b0);
      end
    end
    if ($urandom_range(0, 9) == 0) send_end();
    else send_beat(sls_pkg::CH_QUOTE, 1'b0);
  endtask

  function automatic string token_text(input sls_pkg::result_t t);
    return $sformatf("kind %0d len %0d named %b hex %b uni %b unterm %b taken %b",
                     t.kind, t.length, t.named, t.hex, t.uni, t.unterminated, t.taken);
  endfunction

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    sls_pkg::result_t seen;
    sls_pkg::result_t want;
    if (!rst && token_valid && token_ready) begin
      seen.kind = sls_pkg::token_kind_t'(token_kind);
      seen.length = token_length;
      seen.named = has_named_escape;
      seen.hex = has_hex_escape;
      seen.uni = has_unicode_escape;
      seen.unterminated = unterminated;
      seen.taken = byte_taken;
      tokens_checked++;
      if (pending_tokens.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected token: %s", token_text(seen));
        end
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (seen.kind !== want.kind || seen.length !== want.length ||
            seen.named !== want.named || seen.hex !== want.hex || seen.uni !== want.uni ||
            seen.unterminated !== want.unterminated || seen.taken !== want.taken) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("token mismatch: expected %s", token_text(want));
            $display("                actual   %s", token_text(seen));
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (token_valid && token_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("string_literal_scanner test failed");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin : token_sink
    int gap;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && tokens_checked >= 10) begin
        held = 1'b1;
        rx_holding = 1'b1;
        token_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        token_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      token_ready <= 1'b1;
      do @(posedge clk); while (!token_valid);
    end
  end

  initial begin : stimulus
    int start_beats;
    clear_scan();

    // Directed table: the idle cases, the extremes of the byte, raw and TeX openings that
    // go wrong, and raw and TeX strings that meet end of input.
    add_checked(8'h00, 1'b1, sls_pkg::K_UNKNOWN, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_checked(8'h00, 1'b0, sls_pkg::K_NOT_LIT, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_checked(8'hFF, 1'b0, sls_pkg::K_NOT_LIT, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(sls_pkg::CH_LOWER_R, 1'b0);
    add_row(sls_pkg::CH_HASH, 1'b0);
    add_checked(8'h5A, 1'b0, sls_pkg::K_UNKNOWN, 2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(sls_pkg::CH_LOWER_T, 1'b0);
    add_checked(sls_pkg::CH_LOWER_X, 1'b0, sls_pkg::K_UNKNOWN, 1, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b0);
    add_row(sls_pkg::CH_LOWER_R, 1'b0);
    add_row(sls_pkg::CH_QUOTE, 1'b0);
    add_checked(8'hFF, 1'b1, sls_pkg::K_RAW, 2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(sls_pkg::CH_LOWER_T, 1'b0);
    add_row(sls_pkg::CH_QUOTE, 1'b0);
    add_row(sls_pkg::CH_BACKSLASH, 1'b0);
    add_row(sls_pkg::CH_QUOTE, 1'b0);
    add_checked(8'h00, 1'b1, sls_pkg::K_TEX, 4, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    // Quoted string with a named, a short hex and a braced unicode escape, left open.
    add_row(sls_pkg::CH_QUOTE, 1'b0);
    add_row(sls_pkg::CH_BACKSLASH, 1'b0);
    add_row(sls_pkg::CH_LOWER_N, 1'b0);
    add_row(sls_pkg::CH_BACKSLASH, 1'b0);
    add_row(sls_pkg::CH_LOWER_X, 1'b0);
    add_row(8'h41, 1'b0);
    add_row(sls_pkg::CH_BACKSLASH, 1'b0);
    add_row(sls_pkg::CH_LOWER_U, 1'b0);
    add_row(sls_pkg::CH_LBRACE, 1'b0);
    add_checked(8'h00, 1'b1, sls_pkg::K_QUOTED, 9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    // Random part: mostly well-formed literals with random content, some noise.
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: send_quoted();
        3, 4: send_raw();
        5, 6: send_tex();
        7: send_end();
        default: send_beat(any_byte(), 1'b0);
      endcase
    end

    // Long raw string without gaps: more opening hashes than are counted, closed
    // by a run of the saturated count. End of input first leaves the scanner idle.
    tx_quiet = 1'b1;
    send_end();
    send_beat(sls_pkg::CH_LOWER_R, 1'b0);
    repeat (258) send_beat(sls_pkg::CH_HASH, 1'b0);
    send_beat(sls_pkg::CH_QUOTE, 1'b0);
    send_beat(FILL_BYTE, 1'b0);
    send_beat(sls_pkg::CH_QUOTE, 1'b0);
    repeat (255) send_beat(sls_pkg::CH_HASH, 1'b0);
    byte_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("string_literal_scanner test passed");
    end else begin
      $display("string_literal_scanner test failed");
    end
    $finish;
  end

endmodule
